@@ rtl/core/bvg_pkg.sv @@
// Constants and discharge table shared by the battery voltage gauge.
`timescale 1ns / 1ps

package bvg_pkg;

    // Burst length default and field widths
    localparam int READS_PER_BURST_DEF = 8;
    localparam int SAMPLE_W            = 16;
    localparam int SUM_W               = 24;
    localparam int COUNT_W             = 7;
    localparam int ATTEMPT_W           = 6;
    localparam int MV_W                = 16;
    localparam int PCT_W               = 7;
    localparam int RES_W               = 5;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESOLUTION = 8'd1;
    localparam logic [15:0] FULL_SCALE_RESET = 16'd3600;
    localparam logic [4:0]  RESOLUTION_RESET = 5'd12;

    // Serial datapath widths
    localparam int PROD_W = 32;
    localparam int DVD_W  = 27;
    localparam int DSR_W  = 9;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] MUL_STEPS = 5'd16;
    localparam logic [STEP_W-1:0] DIV_STEPS = 5'd27;

    // Resistor divider ratio
    localparam logic [15:0]      DIV_NUM = 16'd1510;
    localparam logic [DSR_W-1:0] DIV_DEN = 9'd510;

    // Lithium discharge curve, highest voltage first
    localparam int TABLE_LEN = 11;
    localparam logic [MV_W-1:0] CURVE_MV [TABLE_LEN] = '{
        16'd4150, 16'd4050, 16'd3950, 16'd3850, 16'd3800, 16'd3750,
        16'd3700, 16'd3650, 16'd3550, 16'd3400, 16'd3200
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_LEN] = '{
        7'd100, 7'd90, 7'd75, 7'd60, 7'd50, 7'd40,
        7'd30, 7'd20, 7'd10, 7'd5, 7'd0
    };
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

endpackage

@@ rtl/core/battery_voltage_gauge.sv @@
// Battery voltage gauge: burst averaging, millivolt scaling and charge lookup.
`timescale 1ns / 1ps
//
// Usage: each item on the input channel (in_valid/in_ready) is one ADC attempt,
// read_ok plus a signed raw_sample. Good samples are summed over a burst of
// READS_PER_BURST attempts. After the last attempt one result goes out on the
// output channel (out_valid/out_ready): battery_millivolts, charge_percent and
// no_good_reads. Attempts that are not last in a burst give no result.
// Registers are written over cfg_valid/cfg_ready (cfg_ready is always high):
// index 0 is the full scale in mV, index 1 the resolution shift.
// Timing: after the last attempt of a burst in_ready drops while a bit-serial
// sequencer runs: a decision step, a restoring divide for the average, a
// shift-add multiply by the full scale, one-bit right shifts by the resolution,
// a multiply by 1510, a divide by 510, a table step, and for voltages inside
// the curve a multiply and a divide, then a step to post. A burst with no good
// reads or a sum that is not positive goes from the decision to the table step.
// One serial divider and one serial multiplier serve these steps. A finished
// result sits in the output register while the next burst is collected; if it
// is still untaken when the next one is ready, the sequencer waits and in_ready
// stays low. Reset clears the accumulators, the output valid and sets the
// registers to 3600 mV and 12 bits.
//
module battery_voltage_gauge #(
    parameter int READS_PER_BURST = bvg_pkg::READS_PER_BURST_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bvg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bvg_pkg::CFG_DATA_W-1:0]      cfg_data,
    // attempt channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                read_ok,
    input  logic signed [bvg_pkg::SAMPLE_W-1:0] raw_sample,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bvg_pkg::MV_W-1:0]            battery_millivolts,
    output logic [bvg_pkg::PCT_W-1:0]           charge_percent,
    output logic                                no_good_reads
);

    typedef enum logic [3:0] {
        ST_ACC,
        ST_START,
        ST_AVG_DIV,
        ST_PIN_MUL,
        ST_SHIFT,
        ST_BAT_MUL,
        ST_BAT_DIV,
        ST_PCT_SEL,
        ST_PCT_MUL,
        ST_PCT_DIV,
        ST_DONE
    } state_t;

    localparam logic [bvg_pkg::ATTEMPT_W-1:0] LAST_ATTEMPT =
        bvg_pkg::ATTEMPT_W'(READS_PER_BURST - 1);

    state_t state_reg, state_next;

    logic [15:0]                        full_scale_reg, full_scale_next;
    logic [bvg_pkg::RES_W-1:0]          resolution_reg, resolution_next;
    logic signed [bvg_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [bvg_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [bvg_pkg::ATTEMPT_W-1:0]      attempt_reg, attempt_next;

    logic [bvg_pkg::DVD_W-1:0]          dvd_reg, dvd_next;
    logic [bvg_pkg::DSR_W-1:0]          dsr_reg, dsr_next;
    logic [bvg_pkg::DSR_W-1:0]          rem_reg, rem_next;
    logic [bvg_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [15:0]                        mcand_reg, mcand_next;
    logic [15:0]                        mplier_reg, mplier_next;
    logic [bvg_pkg::STEP_W-1:0]         step_reg, step_next;

    logic [bvg_pkg::MV_W-1:0]           mv_reg, mv_next;
    logic [bvg_pkg::PCT_W-1:0]          pct_reg, pct_next;
    logic                               none_reg, none_next;
    logic [3:0]                         seg_reg, seg_next;

    logic                               out_valid_reg, out_valid_next;
    logic [bvg_pkg::MV_W-1:0]           out_mv_reg, out_mv_next;
    logic [bvg_pkg::PCT_W-1:0]          out_pct_reg, out_pct_next;
    logic                               out_none_reg, out_none_next;

    // Serial step results
    logic [bvg_pkg::DSR_W:0]            div_trial;
    logic                               div_ge;
    logic [bvg_pkg::DSR_W-1:0]          div_rem_step;
    logic [bvg_pkg::DVD_W-1:0]          div_dvd_step;
    logic [bvg_pkg::PROD_W-1:0]         mul_prod_step;
    logic [3:0]                         seg_find;
    logic [3:0]                         seg_prev;
    logic [bvg_pkg::MV_W-1:0]           seg_dv;
    logic                               in_fire;

    assign cfg_ready          = 1'b1;
    assign in_ready           = (state_reg == ST_ACC);
    assign in_fire            = in_valid && in_ready;
    assign out_valid          = out_valid_reg;
    assign battery_millivolts = out_mv_reg;
    assign charge_percent     = out_pct_reg;
    assign no_good_reads      = out_none_reg;

    // Restoring divide step: one quotient bit per cycle
    always_comb
    begin
        div_trial    = {rem_reg, dvd_reg[bvg_pkg::DVD_W-1]};
        div_ge       = (div_trial >= {1'b0, dsr_reg});
        div_rem_step = div_ge ? bvg_pkg::DSR_W'(div_trial - {1'b0, dsr_reg})
                              : bvg_pkg::DSR_W'(div_trial);
        div_dvd_step = {dvd_reg[bvg_pkg::DVD_W-2:0], div_ge};
    end

    // Shift-add multiply step, multiplier MSB first
    always_comb
    begin
        mul_prod_step = {prod_reg[bvg_pkg::PROD_W-2:0], 1'b0}
                      + (mplier_reg[15] ? {16'd0, mcand_reg} : {bvg_pkg::PROD_W{1'b0}});
    end

    // Find the curve segment that holds the voltage
    always_comb
    begin
        seg_find = 4'd1;
        for (int i = bvg_pkg::TABLE_LEN - 1; i >= 1; i--)
        begin
            if (mv_reg >= bvg_pkg::CURVE_MV[i])
            begin
                seg_find = 4'(i);
            end
        end
    end

    // Voltage span of the stored segment
    always_comb
    begin
        seg_prev = 4'(seg_reg - 4'd1);
        seg_dv   = bvg_pkg::CURVE_MV[seg_prev] - bvg_pkg::CURVE_MV[seg_reg];
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        full_scale_next = full_scale_reg;
        resolution_next = resolution_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        attempt_next    = attempt_reg;
        dvd_next        = dvd_reg;
        dsr_next        = dsr_reg;
        rem_next        = rem_reg;
        prod_next       = prod_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        step_next       = step_reg;
        mv_next         = mv_reg;
        pct_next        = pct_reg;
        none_next       = none_reg;
        seg_next        = seg_reg;
        out_valid_next  = out_valid_reg;
        out_mv_next     = out_mv_reg;
        out_pct_next    = out_pct_reg;
        out_none_next   = out_none_reg;

        // Take register writes; unknown indexes drop
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == bvg_pkg::REG_FULL_SCALE)
            begin
                full_scale_next = cfg_data;
            end
            else if (cfg_index == bvg_pkg::REG_RESOLUTION)
            begin
                resolution_next = cfg_data[bvg_pkg::RES_W-1:0];
            end
        end

        // Release the output register once the item is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ACC:
            begin
                // Accumulate good samples, close the burst on its last attempt
                if (in_fire)
                begin
                    if (read_ok)
                    begin
                        sum_next   = sum_reg + bvg_pkg::SUM_W'(raw_sample);
                        count_next = count_reg + 1'b1;
                    end
                    if (attempt_reg == LAST_ATTEMPT)
                    begin
                        attempt_next = '0;
                        state_next   = ST_START;
                    end
                    else
                    begin
                        attempt_next = attempt_reg + 1'b1;
                    end
                end
            end
            ST_START:
            begin
                // Decide the special cases, else start the average divide
                none_next = (count_reg == '0);
                if ((count_reg == '0) || sum_reg[bvg_pkg::SUM_W-1] || (sum_reg == '0))
                begin
                    mv_next    = '0;
                    state_next = ST_PCT_SEL;
                end
                else
                begin
                    dvd_next   = bvg_pkg::DVD_W'(sum_reg[bvg_pkg::SUM_W-2:0]);
                    dsr_next   = bvg_pkg::DSR_W'(count_reg);
                    rem_next   = '0;
                    step_next  = bvg_pkg::DIV_STEPS;
                    state_next = ST_AVG_DIV;
                end
                sum_next   = '0;
                count_next = '0;
            end
            ST_AVG_DIV:
            begin
                dvd_next  = div_dvd_step;
                rem_next  = div_rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == 5'd1)
                begin
                    // Average is below 2^15: multiply it by the full scale
                    mcand_next  = div_dvd_step[15:0];
                    mplier_next = full_scale_reg;
                    prod_next   = '0;
                    step_next   = bvg_pkg::MUL_STEPS;
                    state_next  = ST_PIN_MUL;
                end
            end
            ST_PIN_MUL:
            begin
                prod_next   = mul_prod_step;
                mplier_next = {mplier_reg[14:0], 1'b0};
                step_next   = step_reg - 1'b1;
                if (step_reg == 5'd1)
                begin
                    step_next  = resolution_reg;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // Shift one bit per cycle, then clamp pin mV and scale by 1510
                if (step_reg == '0)
                begin
                    mcand_next  = (|prod_reg[bvg_pkg::PROD_W-1:16]) ? 16'hFFFF
                                                                     : prod_reg[15:0];
                    mplier_next = bvg_pkg::DIV_NUM;
                    prod_next   = '0;
                    step_next   = bvg_pkg::MUL_STEPS;
                    state_next  = ST_BAT_MUL;
                end
                else
                begin
                    prod_next = {1'b0, prod_reg[bvg_pkg::PROD_W-1:1]};
                    step_next = step_reg - 1'b1;
                end
            end
            ST_BAT_MUL:
            begin
                prod_next   = mul_prod_step;
                mplier_next = {mplier_reg[14:0], 1'b0};
                step_next   = step_reg - 1'b1;
                if (step_reg == 5'd1)
                begin
                    dvd_next   = mul_prod_step[bvg_pkg::DVD_W-1:0];
                    dsr_next   = bvg_pkg::DIV_DEN;
                    rem_next   = '0;
                    step_next  = bvg_pkg::DIV_STEPS;
                    state_next = ST_BAT_DIV;
                end
            end
            ST_BAT_DIV:
            begin
                dvd_next  = div_dvd_step;
                rem_next  = div_rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == 5'd1)
                begin
                    // Saturate the battery voltage at 16 bits
                    mv_next    = (|div_dvd_step[bvg_pkg::DVD_W-1:16]) ? 16'hFFFF
                                                                       : div_dvd_step[15:0];
                    state_next = ST_PCT_SEL;
                end
            end
            ST_PCT_SEL:
            begin
                // Clamp ends of the curve, else interpolate inside a segment
                if (mv_reg < bvg_pkg::CURVE_MV[bvg_pkg::TABLE_LEN-1])
                begin
                    pct_next   = '0;
                    state_next = ST_DONE;
                end
                else if (mv_reg >= bvg_pkg::CURVE_MV[0])
                begin
                    pct_next   = bvg_pkg::PCT_FULL;
                    state_next = ST_DONE;
                end
                else
                begin
                    seg_next    = seg_find;
                    mcand_next  = mv_reg - bvg_pkg::CURVE_MV[seg_find];
                    mplier_next = 16'(bvg_pkg::CURVE_PCT[4'(seg_find - 4'd1)]
                                    - bvg_pkg::CURVE_PCT[seg_find]);
                    prod_next   = '0;
                    step_next   = bvg_pkg::MUL_STEPS;
                    state_next  = ST_PCT_MUL;
                end
            end
            ST_PCT_MUL:
            begin
                prod_next   = mul_prod_step;
                mplier_next = {mplier_reg[14:0], 1'b0};
                step_next   = step_reg - 1'b1;
                if (step_reg == 5'd1)
                begin
                    dvd_next   = mul_prod_step[bvg_pkg::DVD_W-1:0];
                    dsr_next   = seg_dv[bvg_pkg::DSR_W-1:0];
                    rem_next   = '0;
                    step_next  = bvg_pkg::DIV_STEPS;
                    state_next = ST_PCT_DIV;
                end
            end
            ST_PCT_DIV:
            begin
                dvd_next  = div_dvd_step;
                rem_next  = div_rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == 5'd1)
                begin
                    pct_next   = bvg_pkg::CURVE_PCT[seg_reg]
                               + div_dvd_step[bvg_pkg::PCT_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Post the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_mv_next    = mv_reg;
                    out_pct_next   = pct_reg;
                    out_none_next  = none_reg;
                    state_next     = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // State, control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACC;
            full_scale_reg <= bvg_pkg::FULL_SCALE_RESET;
            resolution_reg <= bvg_pkg::RESOLUTION_RESET;
            sum_reg        <= '0;
            count_reg      <= '0;
            attempt_reg    <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            full_scale_reg <= full_scale_next;
            resolution_reg <= resolution_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            attempt_reg    <= attempt_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        dsr_reg      <= dsr_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        mv_reg       <= mv_next;
        pct_reg      <= pct_next;
        none_reg     <= none_next;
        seg_reg      <= seg_next;
        out_mv_reg   <= out_mv_next;
        out_pct_reg  <= out_pct_next;
        out_none_reg <= out_none_next;
    end

    // Good reads never outnumber the attempts taken so far
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> (count_reg <= {1'b0, attempt_reg}))
        else $error("good read count exceeds attempts in burst");

    // The last attempt of a burst closes it and stops intake
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (attempt_reg == LAST_ATTEMPT)) |=> ((attempt_reg == '0) && !in_ready))
        else $error("burst did not close on its last attempt");

    // A burst without good reads reports zero voltage and charge
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_good_reads) |-> ((battery_millivolts == '0) && (charge_percent == '0)))
        else $error("empty burst reported a nonzero result");

    // Charge stays within the curve and tops out at or above its first point
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((charge_percent <= bvg_pkg::PCT_FULL)
                       && ((battery_millivolts < bvg_pkg::CURVE_MV[0])
                           || (charge_percent == bvg_pkg::PCT_FULL))))
        else $error("charge percent out of range");

endmodule
